[hdl/departure_event_bin_packer_defines.svh]
// assertion macros used by the departure event bin packer controller
`ifndef DEPARTURE_EVENT_BIN_PACKER_DEFINES_SVH
`define DEPARTURE_EVENT_BIN_PACKER_DEFINES_SVH

// plain property checked on every edge outside reset
`define DBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define DBP_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

`endif

[hdl/dbp_pkg.sv]
// types and constants of the departure event bin packer
`default_nettype none

package dbp_pkg;

  // field widths
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned LOC_FIELD_W = 6;
  localparam int unsigned MIN_W       = 15;
  localparam int unsigned BIN_FIELD_W = 4;
  localparam int unsigned ENTRY_W     = TIME_W + LOC_FIELD_W;

  // walking time that marks a missing footpath
  localparam logic [MIN_W-1:0] NO_PATH = 15'h7FFF;
  // travel window after reset
  localparam logic [MIN_W-1:0] MTT_RESET = 15'd1440;

  typedef enum logic [1:0] {
    ACT_CLEAR    = 2'd0,
    ACT_FP_WRITE = 2'd1,
    ACT_EVENT    = 2'd2,
    ACT_NONE     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DROP  = 2'd1,
    STAT_TRUNC = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_META,
    S_ENT,
    S_FP,
    S_PUSH,
    S_PUSH_META,
    S_DONE
  } state_e;

  typedef struct packed {
    action_e                  action;
    logic [TIME_W-1:0]        dep_time;
    logic [LOC_FIELD_W-1:0]   location;
    logic [LOC_FIELD_W-1:0]   other_location;
    logic [MIN_W-1:0]         footpath_minutes;
  } in_t;

  typedef struct packed {
    logic [BIN_FIELD_W-1:0] bin_index;
    logic                   opened_bin;
    status_e                status;
  } out_t;

  // finished result handed from the controller to the output register
  typedef struct packed {
    logic valid;
    out_t data;
  } result_t;

endpackage

`default_nettype wire

[hdl/dbp_ram.sv]
// simple dual port ram with registered read
`default_nettype none

module dbp_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hdl/dbp_ctrl.sv]
// sequencer that walks the bins and entries and updates both memories
`default_nettype none
`include "departure_event_bin_packer_defines.svh"

module dbp_ctrl #(
  parameter int unsigned LOCATIONS  = 64,
  parameter int unsigned MAX_BINS   = 16,
  parameter int unsigned BIN_WINDOW = 32,
  localparam int unsigned LOC_W     = $clog2(LOCATIONS),
  localparam int unsigned FP_AW     = 2 * LOC_W,
  localparam int unsigned ENT_DEPTH = MAX_BINS * (BIN_WINDOW + 1),
  localparam int unsigned ENT_AW    = $clog2(ENT_DEPTH)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire dbp_pkg::in_t                 in_data_i,
  output      logic                         in_stall_o,
  input  wire logic [dbp_pkg::MIN_W-1:0]    max_travel_time_i,
  input  wire logic                         slot_free_i,
  output      dbp_pkg::result_t             res_o,
  // footpath table port
  output      logic                         fp_we_o,
  output      logic [FP_AW-1:0]             fp_waddr_o,
  output      logic [dbp_pkg::MIN_W-1:0]    fp_wdata_o,
  output      logic [FP_AW-1:0]             fp_raddr_o,
  input  wire logic [dbp_pkg::MIN_W-1:0]    fp_rdata_i,
  // bin store port
  output      logic                         ent_we_o,
  output      logic [ENT_AW-1:0]            ent_waddr_o,
  output      logic [dbp_pkg::ENTRY_W-1:0]  ent_wdata_o,
  output      logic [ENT_AW-1:0]            ent_raddr_o,
  input  wire logic [dbp_pkg::ENTRY_W-1:0]  ent_rdata_i
);

  localparam int unsigned BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_BINS + 1);
  localparam int unsigned SLOT_W = (BIN_WINDOW > 1) ? $clog2(BIN_WINDOW) : 1;
  localparam int unsigned FILL_W = $clog2(BIN_WINDOW + 1);
  localparam int unsigned CMP_W  =
    ((LOC_W >= dbp_pkg::LOC_FIELD_W) ? LOC_W : dbp_pkg::LOC_FIELD_W) + 1;
  localparam int unsigned TW     = dbp_pkg::TIME_W;
  localparam int unsigned LW     = dbp_pkg::LOC_FIELD_W;

  // bin b, slot s of the bin store; slot BIN_WINDOW holds head and full flag
  function automatic logic [ENT_AW-1:0] ent_addr(logic [BIN_W-1:0] b, logic [SLOT_W:0] s);
    ent_addr = ENT_AW'(b) * ENT_AW'(BIN_WINDOW + 1) + ENT_AW'(s);
  endfunction

  // ring slot one step back
  function automatic logic [SLOT_W-1:0] slot_dec(logic [SLOT_W-1:0] s);
    slot_dec = (s == '0) ? SLOT_W'(BIN_WINDOW - 1) : s - SLOT_W'(1);
  endfunction

  dbp_pkg::state_e          state_q, state_d;
  logic                     resp_q, resp_d;
  logic [FP_AW-1:0]         sweep_q, sweep_d;
  logic [CNT_W-1:0]         bins_open_q, bins_open_d;
  logic [BIN_W-1:0]         bin_q, bin_d;
  logic [SLOT_W-1:0]        head_q, head_d;
  logic                     full_q, full_d;
  logic [SLOT_W-1:0]        idx_q, idx_d;
  logic [FILL_W-1:0]        left_q, left_d;
  logic [TW-1:0]            ev_time_q, ev_time_d;
  logic [LW-1:0]            ev_loc_q, ev_loc_d;
  logic [TW-1:0]            et_q, et_d;
  dbp_pkg::out_t            res_q, res_d;

  logic                     in_acc;
  logic [TW-1:0]            ent_time;
  logic [LW-1:0]            ent_loc;
  logic                     expired;
  logic                     same_loc;
  logic                     locs_ok;
  logic [LW-1:0]            pair_lo, pair_hi;
  logic                     fp_bad;
  logic                     last_ent;
  logic                     go_accept, go_next, go_fp;
  dbp_pkg::status_e         acc_status;
  logic                     next_bin_ok;
  logic                     can_open;
  logic                     wr_ok;
  logic [LW-1:0]            wr_lo, wr_hi;
  logic                     sweep_last;
  logic [SLOT_W-1:0]        meta_head;
  logic                     meta_full;
  logic [SLOT_W-1:0]        head_next;
  logic                     full_next;
  logic [BIN_W-1:0]         bin_inc;

  // conditions of the current walk step
  always_comb begin
    in_acc      = in_valid_i && (state_q == dbp_pkg::S_IDLE);
    ent_time    = ent_rdata_i[dbp_pkg::ENTRY_W-1:LW];
    ent_loc     = ent_rdata_i[LW-1:0];
    expired     = ({1'b0, ent_time} + (TW + 1)'(max_travel_time_i)) < {1'b0, ev_time_q};
    same_loc    = (ent_loc == ev_loc_q);
    locs_ok     = (CMP_W'(ent_loc) < CMP_W'(LOCATIONS)) &&
                  (CMP_W'(ev_loc_q) < CMP_W'(LOCATIONS));
    pair_lo     = (ent_loc < ev_loc_q) ? ent_loc : ev_loc_q;
    pair_hi     = (ent_loc < ev_loc_q) ? ev_loc_q : ent_loc;
    fp_bad      = (fp_rdata_i == dbp_pkg::NO_PATH) ||
                  ({1'b0, ev_time_q} < ({1'b0, et_q} + (TW + 1)'(fp_rdata_i)));
    last_ent    = (left_q == FILL_W'(1));
    next_bin_ok = (CNT_W'(bin_q) + CNT_W'(1)) < bins_open_q;
    can_open    = bins_open_q < CNT_W'(MAX_BINS);
    sweep_last  = (sweep_q == '1);
    bin_inc     = bin_q + BIN_W'(1);

    go_accept  = 1'b0;
    go_next    = 1'b0;
    go_fp      = 1'b0;
    acc_status = dbp_pkg::STAT_OK;
    // an entry at a location outside the table rejects the bin
    if (state_q == dbp_pkg::S_ENT) begin
      if (expired) begin
        go_accept = 1'b1;
      end else if (same_loc) begin
        go_next = 1'b1;
      end else if (locs_ok) begin
        go_fp = 1'b1;
      end
    end else if (state_q == dbp_pkg::S_FP) begin
      go_next = !fp_bad;
    end
    // walked every stored entry without leaving the travel window
    if (go_next && last_ent) begin
      go_accept  = 1'b1;
      go_next    = 1'b0;
      acc_status = full_q ? dbp_pkg::STAT_TRUNC : dbp_pkg::STAT_OK;
    end

    // footpath write endpoints
    wr_ok = (in_data_i.location != in_data_i.other_location) &&
            (CMP_W'(in_data_i.location) < CMP_W'(LOCATIONS)) &&
            (CMP_W'(in_data_i.other_location) < CMP_W'(LOCATIONS));
    wr_lo = (in_data_i.location < in_data_i.other_location) ?
            in_data_i.location : in_data_i.other_location;
    wr_hi = (in_data_i.location < in_data_i.other_location) ?
            in_data_i.other_location : in_data_i.location;

    // bin metadata as read, and after one more push
    meta_head = ent_rdata_i[SLOT_W-1:0];
    meta_full = ent_rdata_i[SLOT_W];
    head_next = (head_q == SLOT_W'(BIN_WINDOW - 1)) ? '0 : head_q + SLOT_W'(1);
    full_next = full_q || (head_q == SLOT_W'(BIN_WINDOW - 1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dbp_pkg::S_SWEEP: begin
        if (sweep_last) begin
          state_d = resp_q ? dbp_pkg::S_DONE : dbp_pkg::S_IDLE;
        end
      end
      dbp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.action)
            dbp_pkg::ACT_CLEAR:    state_d = dbp_pkg::S_SWEEP;
            dbp_pkg::ACT_FP_WRITE: state_d = dbp_pkg::S_DONE;
            dbp_pkg::ACT_EVENT: begin
              state_d = (bins_open_q != '0) ? dbp_pkg::S_META : dbp_pkg::S_PUSH;
            end
            dbp_pkg::ACT_NONE:     state_d = dbp_pkg::S_DONE;
            default:               state_d = dbp_pkg::S_DONE;
          endcase
        end
      end
      dbp_pkg::S_META: state_d = dbp_pkg::S_ENT;
      dbp_pkg::S_ENT, dbp_pkg::S_FP: begin
        priority if (go_accept) begin
          state_d = dbp_pkg::S_PUSH;
        end else if (go_next) begin
          state_d = dbp_pkg::S_ENT;
        end else if (go_fp) begin
          state_d = dbp_pkg::S_FP;
        end else if (next_bin_ok) begin
          state_d = dbp_pkg::S_META;
        end else if (can_open) begin
          state_d = dbp_pkg::S_PUSH;
        end else begin
          state_d = dbp_pkg::S_DONE;
        end
      end
      dbp_pkg::S_PUSH:      state_d = dbp_pkg::S_PUSH_META;
      dbp_pkg::S_PUSH_META: state_d = dbp_pkg::S_DONE;
      dbp_pkg::S_DONE: begin
        if (slot_free_i) begin
          state_d = dbp_pkg::S_IDLE;
        end
      end
      default: state_d = dbp_pkg::S_IDLE;
    endcase
  end

  // datapath, memory ports and handshake outputs
  always_comb begin
    resp_d      = resp_q;
    sweep_d     = sweep_q;
    bins_open_d = bins_open_q;
    bin_d       = bin_q;
    head_d      = head_q;
    full_d      = full_q;
    idx_d       = idx_q;
    left_d      = left_q;
    ev_time_d   = ev_time_q;
    ev_loc_d    = ev_loc_q;
    et_d        = et_q;
    res_d       = res_q;

    fp_we_o     = 1'b0;
    fp_waddr_o  = {LOC_W'(wr_lo), LOC_W'(wr_hi)};
    fp_wdata_o  = in_data_i.footpath_minutes;
    fp_raddr_o  = {LOC_W'(pair_lo), LOC_W'(pair_hi)};
    ent_we_o    = 1'b0;
    ent_waddr_o = ent_addr(bin_q, {1'b0, head_q});
    ent_wdata_o = {ev_time_q, ev_loc_q};
    ent_raddr_o = ent_addr(bin_q, {1'b0, slot_dec(idx_q)});

    in_stall_o = (state_q != dbp_pkg::S_IDLE);
    res_o.valid = (state_q == dbp_pkg::S_DONE) && slot_free_i;
    res_o.data  = res_q;

    unique case (state_q)
      // footpath table reset, one entry a cycle
      dbp_pkg::S_SWEEP: begin
        fp_we_o    = 1'b1;
        fp_waddr_o = sweep_q;
        fp_wdata_o = dbp_pkg::NO_PATH;
        sweep_d    = sweep_q + FP_AW'(1);
      end
      // take a transaction and set up its work
      dbp_pkg::S_IDLE: begin
        ent_raddr_o = ent_addr('0, (SLOT_W + 1)'(BIN_WINDOW));
        if (in_acc) begin
          res_d     = '{bin_index: '0, opened_bin: 1'b0, status: dbp_pkg::STAT_OK};
          ev_time_d = in_data_i.dep_time;
          ev_loc_d  = in_data_i.location;
          bin_d     = '0;
          unique case (in_data_i.action)
            dbp_pkg::ACT_CLEAR: begin
              sweep_d     = '0;
              resp_d      = 1'b1;
              bins_open_d = '0;
            end
            dbp_pkg::ACT_FP_WRITE: begin
              fp_we_o = wr_ok;
            end
            dbp_pkg::ACT_EVENT: begin
              if (bins_open_q == '0) begin
                head_d      = '0;
                full_d      = 1'b0;
                bins_open_d = CNT_W'(1);
                res_d.opened_bin = 1'b1;
              end
            end
            dbp_pkg::ACT_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      // bin metadata arrived, start at the newest entry
      dbp_pkg::S_META: begin
        head_d      = meta_head;
        full_d      = meta_full;
        left_d      = meta_full ? FILL_W'(BIN_WINDOW) : FILL_W'(meta_head);
        idx_d       = slot_dec(meta_head);
        ent_raddr_o = ent_addr(bin_q, {1'b0, slot_dec(meta_head)});
      end
      // entry check, optionally followed by a footpath check
      dbp_pkg::S_ENT, dbp_pkg::S_FP: begin
        if (state_q == dbp_pkg::S_ENT) begin
          et_d = ent_time;
        end
        priority if (go_accept) begin
          res_d = '{bin_index: dbp_pkg::BIN_FIELD_W'(bin_q), opened_bin: 1'b0,
                    status: acc_status};
        end else if (go_next) begin
          idx_d  = slot_dec(idx_q);
          left_d = left_q - FILL_W'(1);
        end else if (go_fp) begin
          idx_d = idx_q;
        end else if (next_bin_ok) begin
          bin_d       = bin_inc;
          ent_raddr_o = ent_addr(bin_inc, (SLOT_W + 1)'(BIN_WINDOW));
        end else if (can_open) begin
          bin_d       = BIN_W'(bins_open_q);
          head_d      = '0;
          full_d      = 1'b0;
          bins_open_d = bins_open_q + CNT_W'(1);
          res_d = '{bin_index: dbp_pkg::BIN_FIELD_W'(bins_open_q), opened_bin: 1'b1,
                    status: dbp_pkg::STAT_OK};
        end else begin
          res_d = '{bin_index: '0, opened_bin: 1'b0, status: dbp_pkg::STAT_DROP};
        end
      end
      // store the event at the bin head
      dbp_pkg::S_PUSH: begin
        ent_we_o = 1'b1;
      end
      // store the advanced head and full flag
      dbp_pkg::S_PUSH_META: begin
        ent_we_o    = 1'b1;
        ent_waddr_o = ent_addr(bin_q, (SLOT_W + 1)'(BIN_WINDOW));
        ent_wdata_o = dbp_pkg::ENTRY_W'({full_next, head_next});
      end
      dbp_pkg::S_DONE: begin
        resp_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dbp_pkg::S_SWEEP;
      resp_q      <= 1'b0;
      sweep_q     <= '0;
      bins_open_q <= '0;
    end else begin
      state_q     <= state_d;
      resp_q      <= resp_d;
      sweep_q     <= sweep_d;
      bins_open_q <= bins_open_d;
    end
  end

  // walk and result payload
  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    head_q    <= head_d;
    full_q    <= full_d;
    idx_q     <= idx_d;
    left_q    <= left_d;
    ev_time_q <= ev_time_d;
    ev_loc_q  <= ev_loc_d;
    et_q      <= et_d;
    res_q     <= res_d;
  end

  // checks
  `DBP_ASSERT(a_bins_bound, bins_open_q <= CNT_W'(MAX_BINS), "more bins open than exist")
  `DBP_ASSERT_IMP(a_walk_left, state_q == dbp_pkg::S_ENT, left_q != '0, "entry walk past fill")
  `DBP_ASSERT_IMP(a_meta_open, state_q == dbp_pkg::S_META, CNT_W'(bin_q) < bins_open_q, "walk of a bin that is not open")
  `DBP_ASSERT_IMP(a_drop_full, res_o.valid && (res_o.data.status == dbp_pkg::STAT_DROP), (bins_open_q == CNT_W'(MAX_BINS)) && !res_o.data.opened_bin, "drop with a bin still free")

endmodule

`default_nettype wire

[hdl/departure_event_bin_packer.sv]
// top level of the departure event bin packer
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_stall_o  in_data_i (action, time, locations, minutes)
//   out       output     out_valid_o/out_stall_i out_data_o (bin index, opened, status)
//   cfg       input      cfg_we_i               cfg_wdata_i (max travel time)
//
// an event is taken, then each bin tried, stored entry examined and footpath lookup
//   is a step of its own, then the event and bin metadata are stored and the result is
//   handed over (a dropped event skips the store); the walk is set by the single read
//   port of the bin store; footpath writes and unused actions go straight to hand-over
// reset and the clear action run a clearing pass over the footpath table, all of its
//   4**ceil(log2(LOCATIONS)) entries (4096 by default), with no transaction taken
// a finished result sits in the output register while the next transaction runs

`default_nettype none

module departure_event_bin_packer #(
  parameter int unsigned LOCATIONS  = 64,
  parameter int unsigned MAX_BINS   = 16,
  parameter int unsigned BIN_WINDOW = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire dbp_pkg::in_t              in_data_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  output      dbp_pkg::out_t             out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [dbp_pkg::MIN_W-1:0] cfg_wdata_i
);

  localparam int unsigned LOC_W     = $clog2(LOCATIONS);
  localparam int unsigned FP_AW     = 2 * LOC_W;
  localparam int unsigned FP_DEPTH  = 1 << FP_AW;
  localparam int unsigned ENT_DEPTH = MAX_BINS * (BIN_WINDOW + 1);
  localparam int unsigned ENT_AW    = $clog2(ENT_DEPTH);

  logic [dbp_pkg::MIN_W-1:0]   max_travel_time_q;
  logic                        out_valid_q, out_valid_d;
  dbp_pkg::out_t               out_data_q;
  logic                        slot_free;
  dbp_pkg::result_t            res;

  logic                        fp_we;
  logic [FP_AW-1:0]            fp_waddr, fp_raddr;
  logic [dbp_pkg::MIN_W-1:0]   fp_wdata, fp_rdata;
  logic                        ent_we;
  logic [ENT_AW-1:0]           ent_waddr, ent_raddr;
  logic [dbp_pkg::ENTRY_W-1:0] ent_wdata, ent_rdata;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_travel_time_q <= dbp_pkg::MTT_RESET;
    end else if (cfg_we_i) begin
      max_travel_time_q <= cfg_wdata_i;
    end
  end

  // output register
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_data_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // sequencer
  dbp_ctrl #(
    .LOCATIONS  (LOCATIONS),
    .MAX_BINS   (MAX_BINS),
    .BIN_WINDOW (BIN_WINDOW)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_data_i         (in_data_i),
    .in_stall_o        (in_stall_o),
    .max_travel_time_i (max_travel_time_q),
    .slot_free_i       (slot_free),
    .res_o             (res),
    .fp_we_o           (fp_we),
    .fp_waddr_o        (fp_waddr),
    .fp_wdata_o        (fp_wdata),
    .fp_raddr_o        (fp_raddr),
    .fp_rdata_i        (fp_rdata),
    .ent_we_o          (ent_we),
    .ent_waddr_o       (ent_waddr),
    .ent_wdata_o       (ent_wdata),
    .ent_raddr_o       (ent_raddr),
    .ent_rdata_i       (ent_rdata)
  );

  // footpath table, upper triangle addressed by (lower, higher) location
  dbp_ram #(
    .DEPTH (FP_DEPTH),
    .WIDTH (dbp_pkg::MIN_W)
  ) u_fp_ram (
    .clk_i   (clk_i),
    .we_i    (fp_we),
    .waddr_i (fp_waddr),
    .wdata_i (fp_wdata),
    .raddr_i (fp_raddr),
    .rdata_o (fp_rdata)
  );

  // bin store: ring entries and one metadata word per bin
  dbp_ram #(
    .DEPTH (ENT_DEPTH),
    .WIDTH (dbp_pkg::ENTRY_W)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

endmodule

`default_nettype wire
